// File: hw/rtl/rrfp_pkg.sv
// Shared types and constants for the radar report frame parser.
// Used by every module of the block. Depends on nothing.
package rrfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned DIST_W   = 16;

    localparam logic [31:0] TAIL_PATTERN   = 32'h0403_0201;
    localparam logic [31:0] HEADER_PATTERN = 32'hFDFC_FBFA;
    localparam logic [7:0]  TARGET_CMD     = 8'h01;
    localparam logic [7:0]  PRESENT_CODE   = 8'h01;
    localparam logic [7:0]  MIN_FRAME      = 8'd12;

    localparam logic [7:0] POS_HDR_LAST = 8'd3;
    localparam logic [7:0] POS_COMMAND  = 8'd7;
    localparam logic [7:0] POS_PRESENCE = 8'd9;
    localparam logic [7:0] POS_DIST_LO  = 8'd10;
    localparam logic [7:0] POS_DIST_HI  = 8'd11;
    localparam logic [7:0] POS_ENERGY   = 8'd12;

    localparam logic KIND_TARGET = 1'b0;
    localparam logic KIND_OTHER  = 1'b1;

    typedef struct packed {
        logic              target_present;
        logic [DIST_W-1:0] range_cm;
        logic [7:0]        energy;
        logic              report_kind;
    } report_t;

endpackage

// File: hw/rtl/rrfp_parse.sv
// Frame state and report decode for the radar report frame parser.
// Holds the byte count, tail window and captured fields; uses rrfp_pkg.
module rrfp_parse #(
    parameter int BUF_DEPTH = 128
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       byte_accept,
    input  logic [rrfp_pkg::BYTE_W-1:0] rx_byte,
    output logic                       report_hit,
    output rrfp_pkg::report_t          report
);

    localparam logic [rrfp_pkg::COUNT_W-1:0] COUNT_LIMIT = rrfp_pkg::COUNT_W'(BUF_DEPTH);

    logic [rrfp_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [31:0]                  tail_reg, tail_next;
    logic [31:0]                  header_reg, header_next;
    logic [7:0]                   command_reg, command_next;
    logic [7:0]                   presence_reg, presence_next;
    logic [15:0]                  distance_reg, distance_next;
    logic [7:0]                   energy_reg, energy_next;
    logic [rrfp_pkg::COUNT_W-1:0] pos;
    logic [rrfp_pkg::COUNT_W-1:0] count_inc;
    logic                         tail_hit;

    always_comb begin
        pos           = (count_reg >= COUNT_LIMIT) ? '0 : count_reg;
        count_inc     = pos + 1'b1;
        tail_next     = {tail_reg[23:0], rx_byte};
        header_next   = header_reg;
        command_next  = command_reg;
        presence_next = presence_reg;
        distance_next = distance_reg;
        energy_next   = energy_reg;
        if (pos <= rrfp_pkg::POS_HDR_LAST) begin
            case (pos[1:0])
                2'd0:    header_next[31:24] = rx_byte;
                2'd1:    header_next[23:16] = rx_byte;
                2'd2:    header_next[15:8]  = rx_byte;
                default: header_next[7:0]   = rx_byte;
            endcase
        end else if (pos == rrfp_pkg::POS_COMMAND) begin
            command_next = rx_byte;
        end else if (pos == rrfp_pkg::POS_PRESENCE) begin
            presence_next = rx_byte;
        end else if (pos == rrfp_pkg::POS_DIST_LO) begin
            distance_next[7:0] = rx_byte;
        end else if (pos == rrfp_pkg::POS_DIST_HI) begin
            distance_next[15:8] = rx_byte;
        end else if (pos == rrfp_pkg::POS_ENERGY) begin
            energy_next = rx_byte;
        end
        tail_hit   = (pos >= rrfp_pkg::POS_HDR_LAST) && (tail_next == rrfp_pkg::TAIL_PATTERN);
        count_next = tail_hit ? '0 : count_inc;
        report_hit = tail_hit && (count_inc >= rrfp_pkg::MIN_FRAME)
                     && (header_next == rrfp_pkg::HEADER_PATTERN);
        if (command_next == rrfp_pkg::TARGET_CMD) begin
            report.target_present = (presence_next == rrfp_pkg::PRESENT_CODE);
            report.range_cm       = distance_next;
            report.energy         = (count_inc > rrfp_pkg::MIN_FRAME) ? energy_next : 8'd0;
            report.report_kind    = rrfp_pkg::KIND_TARGET;
        end else begin
            report.target_present = 1'b0;
            report.range_cm       = '0;
            report.energy         = '0;
            report.report_kind    = rrfp_pkg::KIND_OTHER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            tail_reg     <= '0;
            header_reg   <= '0;
            command_reg  <= '0;
            presence_reg <= '0;
            distance_reg <= '0;
            energy_reg   <= '0;
        end else if (byte_accept) begin
            count_reg    <= count_next;
            tail_reg     <= tail_next;
            header_reg   <= header_next;
            command_reg  <= command_next;
            presence_reg <= presence_next;
            distance_reg <= distance_next;
            energy_reg   <= energy_next;
        end
    end

endmodule

// File: hw/rtl/rrfp_out.sv
// Output register for the radar report frame parser result stream.
// Holds one report until the sink takes it; uses rrfp_pkg.
module rrfp_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  rrfp_pkg::report_t report,
    input  logic              m_ready,
    output logic              m_valid,
    output rrfp_pkg::report_t m_report,
    output logic              can_load
);

    logic              valid_reg, valid_next;
    rrfp_pkg::report_t report_reg, report_next;

    always_comb begin
        can_load    = !valid_reg || m_ready;
        valid_next  = valid_reg;
        report_next = report_reg;
        if (load) begin
            valid_next  = 1'b1;
            report_next = report;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        report_reg <= report_next;
    end

    assign m_valid  = valid_reg;
    assign m_report = report_reg;

endmodule

// File: hw/rtl/radar_report_frame_parser.sv
// Top level of the radar report frame parser.
// Instantiates rrfp_parse and rrfp_out; uses rrfp_pkg.
//
//  Channel  | Direction | tdata                               | tuser
//  s_axis   | in        | [7:0] rx_byte                       | none
//  m_axis   | out       | [0] present, [16:1] dist, [24:17] e | [0] report_kind
//
// One byte is taken per cycle while s_axis_tready is high; a report appears on m_axis in the cycle
// after the byte that closes a valid frame. The single output register sets the rate.
// Reset is synchronous and clears the frame state and the output valid flag.
// While a report waits and m_axis_tready is low, s_axis_tready is low.
module radar_report_frame_parser #(
    parameter int BUF_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] target_present, [16:1] range_cm, [24:17] energy
    output logic [0:0]  m_axis_tuser    // [0] report_kind
);

    logic              byte_accept;
    logic              report_hit;
    logic              can_load;
    rrfp_pkg::report_t report;
    rrfp_pkg::report_t m_report;

    assign s_axis_tready = can_load;
    assign byte_accept   = s_axis_tvalid && can_load;

    rrfp_parse #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_accept(byte_accept),
        .rx_byte    (s_axis_tdata),
        .report_hit (report_hit),
        .report     (report)
    );

    rrfp_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (byte_accept && report_hit),
        .report  (report),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_report(m_report),
        .can_load(can_load)
    );

    assign m_axis_tdata = {7'd0, m_report.energy, m_report.range_cm, m_report.target_present};
    assign m_axis_tuser = m_report.report_kind;

endmodule

// File: hw/rtl/rrfp_checker.sv
// Port-level checks for the radar report frame parser.
// Bound to radar_report_frame_parser; uses rrfp_pkg.
module rrfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    property p_reset_clears_valid;
        @(posedge aclk) !aresetn |=> !m_axis_tvalid;
    endproperty
    a_reset_clears_valid: assert property (p_reset_clears_valid)
        else $error("Result valid after reset.");

    property p_hold_when_stalled;
        @(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty
    a_hold_when_stalled: assert property (p_hold_when_stalled)
        else $error("Stalled result transaction changed.");

    property p_backpressure;
        @(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready;
    endproperty
    a_backpressure: assert property (p_backpressure)
        else $error("Input accepted while a result is stalled.");

    property p_other_zero;
        @(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser[0] == rrfp_pkg::KIND_OTHER) |-> m_axis_tdata == 32'd0;
    endproperty
    a_other_zero: assert property (p_other_zero)
        else $error("Other-command report carries nonzero data.");

endmodule

bind radar_report_frame_parser rrfp_checker u_rrfp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

// File: dv/radar_report_frame_parser_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for radar_report_frame_parser: directed frames, then random traffic.
// Predicts reports with its own parser model; needs rrfp_pkg and the block's RTL.
module radar_report_frame_parser_test;

    localparam int BUF_DEPTH   = 128;
    localparam int ITEM_TARGET = 1400;
    localparam int STALL_LIMIT = 2000;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_t;

    typedef struct packed {
        chk_t              chk;
        logic [7:0]        fill_n;
        logic [7:0]        fill_b;
        logic [5:0]        len;
        logic [255:0]      seq;
        rrfp_pkg::report_t want;
    } frame_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    logic [7:0]  frame_len = '0;
    logic [31:0] tail_bytes = '0;
    logic [31:0] header_word = '0;
    logic [7:0]  command_val = '0;
    logic [7:0]  presence_val = '0;
    logic [15:0] distance_val = '0;
    logic [7:0]  energy_val = '0;

    rrfp_pkg::report_t pending_reports[$];
    frame_row_t        frame_rows[$];
    rrfp_pkg::report_t oldest;
    bit          no_gaps = 1'b0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          overflows = 0;
    int          target_seen = 0;
    int          other_seen = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          ready_left = 0;
    int          stall_left = 0;

    radar_report_frame_parser #(
        .BUF_DEPTH(BUF_DEPTH)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic note_error(input string what, input logic [31:0] got, input logic [31:0] want);
        if (mismatches < 100) begin
            $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic parse_byte(input logic [7:0] b, output bit got, output rrfp_pkg::report_t rep);
        logic [7:0] pos;
        logic [7:0] n;
        got = 1'b0;
        rep = '0;
        pos = frame_len;
        if (pos >= BUF_DEPTH) begin
            pos = '0;
            overflows++;
        end
        if (pos <= rrfp_pkg::POS_HDR_LAST) begin
            header_word[(3 - pos) * 8 +: 8] = b;
        end else if (pos == rrfp_pkg::POS_COMMAND) begin
            command_val = b;
        end else if (pos == rrfp_pkg::POS_PRESENCE) begin
            presence_val = b;
        end else if (pos == rrfp_pkg::POS_DIST_LO) begin
            distance_val[7:0] = b;
        end else if (pos == rrfp_pkg::POS_DIST_HI) begin
            distance_val[15:8] = b;
        end else if (pos == rrfp_pkg::POS_ENERGY) begin
            energy_val = b;
        end
        tail_bytes = {tail_bytes[23:0], b};
        n = pos + 8'd1;
        frame_len = n;
        if (n >= 8'd4 && tail_bytes == rrfp_pkg::TAIL_PATTERN) begin
            frame_len = '0;
            if (n >= rrfp_pkg::MIN_FRAME && header_word == rrfp_pkg::HEADER_PATTERN) begin
                got = 1'b1;
                if (command_val == rrfp_pkg::TARGET_CMD) begin
                    rep.target_present = (presence_val == rrfp_pkg::PRESENT_CODE);
                    rep.range_cm = distance_val;
                    rep.energy = (n > rrfp_pkg::MIN_FRAME) ? energy_val : 8'h00;
                    rep.report_kind = rrfp_pkg::KIND_TARGET;
                end else begin
                    rep.report_kind = rrfp_pkg::KIND_OTHER;
                end
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit from_model);
        int gap;
        bit got;
        rrfp_pkg::report_t rep;
        gap = no_gaps ? 0 : gap_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
        parse_byte(b, got, rep);
        if (got && from_model) begin
            pending_reports.push_back(rep);
        end
    endtask

    task automatic drain_reports();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic add_row(input chk_t c, input int fill_n, input logic [7:0] fill_b,
                           input int len, input logic [255:0] seq, input logic p,
                           input logic [15:0] d, input logic [7:0] e, input logic kd);
        frame_row_t r;
        r.chk = c;
        r.fill_n = 8'(fill_n);
        r.fill_b = fill_b;
        r.len = 6'(len);
        r.seq = seq;
        r.want.target_present = p;
        r.want.range_cm = d;
        r.want.energy = e;
        r.want.report_kind = kd;
        frame_rows.push_back(r);
    endtask

    task automatic send_frame(input bit hdr_bad, input int body_n, input logic [7:0] cmd);
        logic [7:0] fr[$];
        int j;
        int h;
        for (j = 0; j < 4; j++) begin
            fr.push_back(rrfp_pkg::HEADER_PATTERN[(3 - j) * 8 +: 8]);
        end
        for (j = 0; j < body_n; j++) begin
            fr.push_back(8'($urandom_range(0, 255)));
        end
        if (body_n > 3) fr[rrfp_pkg::POS_COMMAND] = cmd;
        if (body_n > 5 && $urandom_range(0, 1) == 1) begin
            fr[rrfp_pkg::POS_PRESENCE] = rrfp_pkg::PRESENT_CODE;
        end
        if (hdr_bad) begin
            h = $urandom_range(0, 3);
            fr[h] = fr[h] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (j = 0; j < 4; j++) begin
            fr.push_back(rrfp_pkg::TAIL_PATTERN[(3 - j) * 8 +: 8]);
        end
        for (j = 0; j < fr.size(); j++) begin
            send_byte(fr[j], 1'b1);
        end
        frames_sent++;
    endtask

    always @(negedge aclk) begin
        if (ready_left > 0) begin
            m_axis_tready <= 1'b1;
            ready_left = ready_left - 1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 6);
            stall_left = gap_len();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                note_error("report with none expected", m_axis_tdata, 32'h0);
            end else begin
                oldest = pending_reports.pop_front();
                if (m_axis_tdata[0] !== oldest.target_present)
                    note_error("target_present", 32'(m_axis_tdata[0]),
                               32'(oldest.target_present));
                if (m_axis_tdata[16:1] !== oldest.range_cm)
                    note_error("range_cm", 32'(m_axis_tdata[16:1]), 32'(oldest.range_cm));
                if (m_axis_tdata[24:17] !== oldest.energy)
                    note_error("energy", 32'(m_axis_tdata[24:17]), 32'(oldest.energy));
                if (m_axis_tdata[31:25] !== 7'h00)
                    note_error("tdata padding", 32'(m_axis_tdata[31:25]), 32'h0);
                if (m_axis_tuser[0] !== oldest.report_kind)
                    note_error("report_kind", 32'(m_axis_tuser[0]), 32'(oldest.report_kind));
                if (oldest.report_kind == rrfp_pkg::KIND_TARGET) target_seen++;
                else other_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int i;
        int k;
        int r;
        int n;
        frame_row_t row;

        add_row(CHK_NONE, 0, 8'h00, 4, 256'h04030201, 1'b0, 16'h0000, 8'h00,
                rrfp_pkg::KIND_TARGET);
        add_row(CHK_TYPED, 0, 8'h00, 12, 256'hFDFCFBFA_111111_01_04030201,
                1'b0, 16'h0102, 8'h00, rrfp_pkg::KIND_TARGET);
        add_row(CHK_TYPED, 0, 8'h00, 17, 256'hFDFCFBFA_000000_01_00_01_FFFF_FF_04030201,
                1'b1, 16'hFFFF, 8'hFF, rrfp_pkg::KIND_TARGET);
        add_row(CHK_TYPED, 0, 8'h00, 17, 256'hFDFCFBFA_FFFFFF_01_FF_00_0000_00_04030201,
                1'b0, 16'h0000, 8'h00, rrfp_pkg::KIND_TARGET);
        add_row(CHK_TYPED, 0, 8'h00, 17, 256'hFDFCFBFA_000000_02_00_01_3412_56_04030201,
                1'b0, 16'h0000, 8'h00, rrfp_pkg::KIND_OTHER);
        add_row(CHK_MODEL, 0, 8'h00, 17, 256'hFDFCFBFA_A5A5A5_FF_5A_01_8001_80_04030201,
                1'b0, 16'h0000, 8'h00, rrfp_pkg::KIND_TARGET);
        add_row(CHK_NONE, 0, 8'h00, 17, 256'hFDFCFBFB_000000_01_00_01_1234_56_04030201,
                1'b0, 16'h0000, 8'h00, rrfp_pkg::KIND_TARGET);
        add_row(CHK_NONE, 0, 8'h00, 8, 256'hFDFCFBFA_04030201, 1'b0, 16'h0000, 8'h00,
                rrfp_pkg::KIND_TARGET);
        add_row(CHK_MODEL, 0, 8'h00, 20, 256'hFDFCFBFA_0A0B0C_01_0D_01_8040_7F_112233_04030201,
                1'b0, 16'h0000, 8'h00, rrfp_pkg::KIND_TARGET);
        add_row(CHK_MODEL, 0, 8'h00, 13, 256'hFDFCFBFA_AABBCC_01_EE_04030201,
                1'b0, 16'h0000, 8'h00, rrfp_pkg::KIND_TARGET);
        add_row(CHK_TYPED, 128, 8'h5A, 17, 256'hFDFCFBFA_000000_01_00_01_CDAB_EF_04030201,
                1'b1, 16'hABCD, 8'hEF, rrfp_pkg::KIND_TARGET);
        add_row(CHK_NONE, 127, 8'h00, 4, 256'h04030201, 1'b0, 16'h0000, 8'h00,
                rrfp_pkg::KIND_TARGET);
        add_row(CHK_NONE, 0, 8'h00, 4, 256'h04030201, 1'b0, 16'h0000, 8'h00,
                rrfp_pkg::KIND_TARGET);
        add_row(CHK_MODEL, 126, 8'hC3, 17, 256'hFDFCFBFA_000000_01_00_01_2211_33_04030201,
                1'b0, 16'h0000, 8'h00, rrfp_pkg::KIND_TARGET);
        add_row(CHK_MODEL, 0, 8'h00, 25,
                256'hFDFCFBFA_04030201_FDFCFBFA_000000_01_00_01_1111_22_04030201,
                1'b0, 16'h0000, 8'h00, rrfp_pkg::KIND_TARGET);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < frame_rows.size(); i++) begin
            row = frame_rows[i];
            no_gaps = (i % 3 == 0);
            for (k = 0; k < row.fill_n; k++) begin
                send_byte(row.fill_b, row.chk == CHK_MODEL);
            end
            for (k = 0; k < row.len; k++) begin
                send_byte(row.seq[(row.len - 1 - k) * 8 +: 8], row.chk == CHK_MODEL);
            end
            if (row.chk == CHK_TYPED) begin
                pending_reports.push_back(row.want);
            end
            frames_sent++;
        end
        drain_reports();

        while (bytes_sent < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 75) begin
                k = $urandom_range(0, 99);
                if (k < 10) n = 4;
                else if (k < 20) n = 5;
                else if (k < 85) n = $urandom_range(6, 12);
                else if (k < 97) n = $urandom_range(13, 30);
                else n = $urandom_range(115, 124);
                send_frame(1'b0, n, ($urandom_range(0, 3) != 0) ? rrfp_pkg::TARGET_CMD
                                                                : 8'($urandom_range(0, 255)));
            end else if (r < 85) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_frame(1'b1, $urandom_range(4, 12), rrfp_pkg::TARGET_CMD);
                end else begin
                    send_frame(1'b0, $urandom_range(0, 3), rrfp_pkg::TARGET_CMD);
                end
            end else begin
                n = (r < 98) ? $urandom_range(1, 24) : $urandom_range(120, 200);
                for (k = 0; k < n; k++) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                end
                if ($urandom_range(0, 2) == 0) begin
                    for (k = 0; k < 4; k++) begin
                        send_byte(rrfp_pkg::TAIL_PATTERN[(3 - k) * 8 +: 8], 1'b1);
                    end
                end
            end
            if ($urandom_range(0, 39) == 0) begin
                drain_reports();
            end
        end

        drain_reports();
        repeat (10) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            note_error("reports never delivered", 32'h0, pending_reports.size());
        end

        $display("Sent %0d bytes in %0d frames plus noise runs, with %0d buffer overflows.",
                 bytes_sent, frames_sent, overflows);
        $display("Checked %0d target reports and %0d other-command reports, %0d mismatches.",
                 target_seen, other_seen, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
